// ===== sv/swmm_pkg.sv =====
// ---------------------------------------------------------------------------
// swmm_pkg
// Shared constants and types for the sliding window min/max block.
// ---------------------------------------------------------------------------
package swmm_pkg;

    localparam int WINDOW_MAX   = 64;
    localparam int SAMPLE_WIDTH = 30;
    localparam int CFG_WIDTH    = 7;

    // window length / fill count must hold WINDOW_MAX itself
    localparam int LEN_W = $clog2(WINDOW_MAX + 1);
    // scan countdown holds at most WINDOW_MAX - 1
    localparam int CNT_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_ONES = '1;
    localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_ZERO = '0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } swmm_state_t;

    // per-cycle commands broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic reduce;
    } swmm_cell_ctrl_t;

endpackage

// ===== sv/swmm_cell.sv =====
// ---------------------------------------------------------------------------
// swmm_cell
// One window slot: holds a sample and a running min/max that collapses
// toward the head of the chain during a scan.
// ---------------------------------------------------------------------------
module swmm_cell
    import swmm_pkg::*;
(
    input  logic                    clk,
    input  swmm_cell_ctrl_t         ctrl,
    input  logic                    in_span,
    input  logic [SAMPLE_WIDTH-1:0] prev_sample,
    input  logic [SAMPLE_WIDTH-1:0] nb_min,
    input  logic [SAMPLE_WIDTH-1:0] nb_max,
    output logic [SAMPLE_WIDTH-1:0] sample_q,
    output logic [SAMPLE_WIDTH-1:0] acc_min,
    output logic [SAMPLE_WIDTH-1:0] acc_max
);

    logic [SAMPLE_WIDTH-1:0] sample_reg;
    logic [SAMPLE_WIDTH-1:0] sample_next;
    logic [SAMPLE_WIDTH-1:0] min_reg;
    logic [SAMPLE_WIDTH-1:0] min_next;
    logic [SAMPLE_WIDTH-1:0] max_reg;
    logic [SAMPLE_WIDTH-1:0] max_next;

    always_comb
    begin
        sample_next = sample_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        if (ctrl.shift)
        begin
            sample_next = prev_sample;
            // slots outside the window start neutral
            min_next    = in_span ? prev_sample : SAMPLE_ONES;
            max_next    = in_span ? prev_sample : SAMPLE_ZERO;
        end
        else if (ctrl.reduce)
        begin
            min_next = (nb_min < min_reg) ? nb_min : min_reg;
            max_next = (nb_max > max_reg) ? nb_max : max_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg <= sample_next;
        min_reg    <= min_next;
        max_reg    <= max_next;
    end

    assign sample_q = sample_reg;
    assign acc_min  = min_reg;
    assign acc_max  = max_reg;

endmodule

// ===== sv/swmm_ctrl.sv =====
// ---------------------------------------------------------------------------
// swmm_ctrl
// Sequencer: window length register, fill count, scan countdown and
// output handshake.
// ---------------------------------------------------------------------------
module swmm_ctrl
    import swmm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 last,
    output logic                 in_stall,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_WIDTH-1:0] cfg_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 partial,
    output logic                 stream_end,
    output swmm_cell_ctrl_t      cell_ctrl,
    output logic [LEN_W-1:0]     span,
    output logic                 out_load
);

    swmm_state_t          state_reg;
    swmm_state_t          state_next;
    logic [CFG_WIDTH-1:0] len_reg;
    logic [CFG_WIDTH-1:0] len_next;
    logic [LEN_W-1:0]     fill_reg;
    logic [LEN_W-1:0]     fill_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic                 item_part_reg;
    logic                 item_part_next;
    logic                 item_end_reg;
    logic                 item_end_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_part_reg;
    logic                 out_part_next;
    logic                 out_end_reg;
    logic                 out_end_next;

    logic [LEN_W-1:0]     eff_len;
    logic [LEN_W-1:0]     fill_inc;
    logic                 accept;
    logic                 out_free;

    always_comb
    begin
        if (len_reg == '0)
            eff_len = LEN_W'(1);
        else if (32'(len_reg) > WINDOW_MAX)
            eff_len = LEN_W'(WINDOW_MAX);
        else
            eff_len = LEN_W'(len_reg);

        fill_inc = (fill_reg < LEN_W'(WINDOW_MAX)) ? fill_reg + LEN_W'(1) : fill_reg;

        priority if (fill_inc >= eff_len)
            span = eff_len;
        else if (last)
            span = fill_inc;
        else
            span = '0;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        len_next       = len_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        item_part_next = item_part_reg;
        item_end_next  = item_end_reg;
        out_part_next  = out_part_reg;
        out_end_next   = out_end_reg;
        out_load       = 1'b0;
        cell_ctrl      = '0;

        if (cfg_valid && cfg_ready)
            len_next = cfg_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_ctrl.shift = 1'b1;
                    fill_next       = last ? '0 : fill_inc;
                    item_part_next  = last && (fill_inc < eff_len);
                    item_end_next   = last;
                    if (span != '0)
                    begin
                        cnt_next   = CNT_W'(span - LEN_W'(1));
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg != '0)
                begin
                    cell_ctrl.reduce = 1'b1;
                    cnt_next         = cnt_reg - CNT_W'(1);
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                    state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (out_load)
        begin
            out_part_next = item_part_reg;
            out_end_next  = item_end_reg;
        end

        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= CFG_WIDTH'(1);
            fill_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_part_reg <= item_part_next;
        item_end_reg  <= item_end_next;
        out_part_reg  <= out_part_next;
        out_end_reg   <= out_end_next;
    end

    assign out_valid  = out_valid_reg;
    assign partial    = out_part_reg;
    assign stream_end = out_end_reg;

endmodule

// ===== sv/sliding_window_min_max.sv =====
// ---------------------------------------------------------------------------
// sliding_window_min_max
// Min and max over the most recent samples of a stream.
// ---------------------------------------------------------------------------
// Input words (sample, last) arrive on in_valid/in_stall; result words
// (window_min, window_max, partial, stream_end) leave on out_valid/out_stall.
// The window length is written through cfg_valid/cfg_ready/cfg_data, which
// the user must do only while the block is idle; the block does not enforce
// this. cfg_ready is always high. Reset sets the length to one. Samples
// shift into a chain of WINDOW_MAX cells. A sample that completes a window
// (or ends a short stream) loads each cell's running min/max, then the chain
// folds neighbor into neighbor toward the head, one cell per cycle. A sample
// yielding a result over N samples (N = window length, or the short stream's
// length) stalls the input until that result is shown; the next sample can
// be taken in the first cycle that result is shown. A sample yielding no
// result does not stall the input. The fold sets the length of the stall.
// The finished result sits in an output register, so the block takes the
// next sample while the receiver stalls; a second result waits inside the
// block with in_stall high until the output register frees up.
// After reset the fill count and stream position are cleared; a sample with
// last set ends the stream and the next sample starts a new one.
// ---------------------------------------------------------------------------
module sliding_window_min_max
    import swmm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic [SAMPLE_WIDTH-1:0] sample,
    input  logic                    last,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic [SAMPLE_WIDTH-1:0] window_min,
    output logic [SAMPLE_WIDTH-1:0] window_max,
    output logic                    partial,
    output logic                    stream_end,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_WIDTH-1:0]    cfg_data
);

    swmm_cell_ctrl_t         cell_ctrl;
    logic [LEN_W-1:0]        span;
    logic                    out_load;

    logic [SAMPLE_WIDTH-1:0] cell_sample [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] cell_min    [WINDOW_MAX];
    logic [SAMPLE_WIDTH-1:0] cell_max    [WINDOW_MAX];

    logic [SAMPLE_WIDTH-1:0] min_reg;
    logic [SAMPLE_WIDTH-1:0] min_next;
    logic [SAMPLE_WIDTH-1:0] max_reg;
    logic [SAMPLE_WIDTH-1:0] max_next;

    swmm_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .last       (last),
        .in_stall   (in_stall),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .partial    (partial),
        .stream_end (stream_end),
        .cell_ctrl  (cell_ctrl),
        .span       (span),
        .out_load   (out_load)
    );

    // cell 0 holds the newest sample
    for (genvar k = 0; k < WINDOW_MAX; k++)
    begin : g_cell
        logic [SAMPLE_WIDTH-1:0] prev_sample;
        logic [SAMPLE_WIDTH-1:0] nb_min;
        logic [SAMPLE_WIDTH-1:0] nb_max;
        logic                    in_span;

        if (k == 0)
        begin : g_head
            assign prev_sample = sample;
        end
        else
        begin : g_body
            assign prev_sample = cell_sample[k-1];
        end

        if (k == WINDOW_MAX - 1)
        begin : g_tail
            assign nb_min = SAMPLE_ONES;
            assign nb_max = SAMPLE_ZERO;
        end
        else
        begin : g_inner
            assign nb_min = cell_min[k+1];
            assign nb_max = cell_max[k+1];
        end

        assign in_span = (LEN_W'(k) < span);

        swmm_cell u_cell (
            .clk         (clk),
            .ctrl        (cell_ctrl),
            .in_span     (in_span),
            .prev_sample (prev_sample),
            .nb_min      (nb_min),
            .nb_max      (nb_max),
            .sample_q    (cell_sample[k]),
            .acc_min     (cell_min[k]),
            .acc_max     (cell_max[k])
        );
    end

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (out_load)
        begin
            min_next = cell_min[0];
            max_next = cell_max[0];
        end
    end

    always_ff @(posedge clk)
    begin
        min_reg <= min_next;
        max_reg <= max_next;
    end

    assign window_min = min_reg;
    assign window_max = max_reg;

endmodule

// ===== sv/swmm_check.sv =====
// ---------------------------------------------------------------------------
// swmm_check
// Port-level assertions for sliding_window_min_max.
// ---------------------------------------------------------------------------
module swmm_check
    import swmm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_stall,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  logic [SAMPLE_WIDTH-1:0] window_min,
    input  logic [SAMPLE_WIDTH-1:0] window_max,
    input  logic                    partial,
    input  logic                    stream_end
);

    // min and max come from the same set of samples
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (window_min <= window_max))
        else $error("window_min above window_max");

    // a short window only shows up on the stream's last word
    a_partial_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && partial |-> stream_end)
        else $error("partial result without stream_end");

    // a new result is only produced while the input side is busy
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no sample in flight");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(window_min)
            && $stable(window_max) && $stable(partial) && $stable(stream_end))
        else $error("stalled result word changed");

endmodule

bind sliding_window_min_max swmm_check u_swmm_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .window_min (window_min),
    .window_max (window_max),
    .partial    (partial),
    .stream_end (stream_end)
);
